/* rtl/gbh_pkg.sv */
package gbh_pkg;

    localparam logic [63:0] HASH_INIT = 64'hE819F743DE590AB0;
    localparam int          ROT_LEFT  = 11;
    localparam int          ROUNDS    = 32;
    localparam int          RND_W     = $clog2(ROUNDS);

    typedef logic [RND_W-1:0] round_idx_t;

    typedef struct packed {
        logic [63:0] data;
        logic        absorb;
        logic        last;
    } blk_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } core_state_t;

    localparam logic [3:0] SBOX [8][16] = '{
        '{4'h4, 4'h2, 4'hF, 4'h5, 4'h9, 4'h1, 4'h0, 4'h8,
          4'hE, 4'h3, 4'hB, 4'hC, 4'hD, 4'h7, 4'hA, 4'h6},
        '{4'hC, 4'h9, 4'hF, 4'hE, 4'h8, 4'h1, 4'h3, 4'hA,
          4'h2, 4'h7, 4'h4, 4'hD, 4'h6, 4'h0, 4'hB, 4'h5},
        '{4'hD, 4'hF, 4'hE, 4'hC, 4'h7, 4'h3, 4'h9, 4'hA,
          4'h1, 4'h5, 4'h2, 4'h4, 4'h6, 4'h8, 4'h0, 4'hB},
        '{4'hE, 4'h9, 4'hB, 4'h2, 4'h5, 4'hF, 4'h7, 4'h1,
          4'h0, 4'hD, 4'hC, 4'h6, 4'hA, 4'h4, 4'h3, 4'h8},
        '{4'h3, 4'hE, 4'h5, 4'h9, 4'h6, 4'h8, 4'h0, 4'hD,
          4'hA, 4'hB, 4'h7, 4'hC, 4'h2, 4'h1, 4'hF, 4'h4},
        '{4'h8, 4'hF, 4'h6, 4'hB, 4'h1, 4'h9, 4'hC, 4'h5,
          4'hD, 4'h3, 4'h7, 4'hA, 4'h0, 4'hE, 4'h2, 4'h4},
        '{4'hA, 4'hB, 4'hC, 4'h0, 4'h3, 4'h6, 4'h7, 4'h5,
          4'h4, 4'h8, 4'hE, 4'hF, 4'h1, 4'h9, 4'h2, 4'hD},
        '{4'hC, 4'h6, 4'h5, 4'h2, 4'hB, 4'h0, 4'h9, 4'hD,
          4'h3, 4'hE, 4'h7, 4'hA, 4'hF, 4'h4, 4'h1, 4'h8}
    };

    localparam logic [31:0] KEY [8] = '{
        32'hC9C02774, 32'h52A2E838, 32'h9C04B513, 32'h4F155F55,
        32'h923A7F1A, 32'hE284730F, 32'h14AB6F0F, 32'hDCF0F7A5
    };

    // rounds 0..23 use key words 0..7 in turn, rounds 24..31 run them backwards
    function automatic logic [2:0] key_index(input round_idx_t rnd);
        return (rnd[RND_W-1:3] == '1) ? ~rnd[2:0] : rnd[2:0];
    endfunction

    function automatic logic [63:0] cipher_round(input logic [63:0] blk,
                                                 input logic [2:0]  kidx);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] sum;
        logic [31:0] sub;
        logic [31:0] rot;
        lo  = blk[31:0];
        hi  = blk[63:32];
        sum = lo + KEY[kidx];
        for (int k = 0; k < 8; k++) begin
            sub[4*k +: 4] = SBOX[k][sum[4*k +: 4]];
        end
        rot = {sub[31-ROT_LEFT:0], sub[31:32-ROT_LEFT]};
        return {lo, hi ^ rot};
    endfunction

    function automatic logic [63:0] half_swap(input logic [63:0] blk);
        return {blk[31:0], blk[63:32]};
    endfunction

    // elaboration-time only: chain start value
    function automatic logic [63:0] encrypt_block(input logic [63:0] blk);
        logic [63:0] b;
        b = blk;
        for (int r = 0; r < ROUNDS; r++) begin
            b = cipher_round(b, key_index(RND_W'(r)));
        end
        return half_swap(b);
    endfunction

    localparam logic [63:0] HASH_IV = encrypt_block(HASH_INIT);

endpackage

/* rtl/gbh_front.sv */
module gbh_front
    import gbh_pkg::*;
(
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_data,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last,
    output logic        push,
    output blk_item_t   push_item,
    input  logic        full
);

    logic [63:0] masked;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked[8*i +: 8] = (4'(i) < s_byte_count) ? s_block_data[8*i +: 8] : 8'h00;
        end
    end

    assign s_ready          = aresetn && !full;
    assign push             = s_valid && s_ready;
    assign push_item.data   = masked;
    assign push_item.absorb = (s_byte_count != 4'd0);
    assign push_item.last   = s_last;

endmodule

/* rtl/gbh_queue.sv */
module gbh_queue
    import gbh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  blk_item_t push_item,
    output logic      full,
    input  logic      pop,
    output blk_item_t pop_item,
    output logic      empty
);

    blk_item_t   slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/gbh_core.sv */
module gbh_core
    import gbh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        empty,
    input  blk_item_t   pop_item,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest
);

    core_state_t state_reg, state_next;
    round_idx_t  rnd_reg, rnd_next;
    logic [63:0] blk_reg, blk_next;
    logic [63:0] chain_reg, chain_next;
    logic        last_reg, last_next;
    logic        valid_reg, valid_next;
    logic [63:0] digest_reg, digest_next;
    logic [63:0] round_out;
    logic        out_free;

    assign round_out = cipher_round(blk_reg, key_index(rnd_reg));
    assign out_free  = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_digest  = digest_reg;

    always_comb begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        blk_next    = blk_reg;
        chain_next  = chain_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !m_ready;
        digest_next = digest_reg;
        pop         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!empty) begin
                    pop       = 1'b1;
                    last_next = pop_item.last;
                    blk_next  = pop_item.data ^ chain_reg;
                    rnd_next  = '0;
                    state_next = pop_item.absorb ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN: begin
                blk_next = round_out;
                rnd_next = rnd_reg + round_idx_t'(1);
                if (rnd_reg == round_idx_t'(ROUNDS - 1)) begin
                    chain_next = half_swap(round_out);
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    valid_next  = 1'b1;
                    digest_next = chain_reg;
                    chain_next  = HASH_IV;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            chain_reg <= HASH_IV;
            last_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg    <= blk_next;
        digest_reg <= digest_next;
    end

endmodule

/* rtl/gost_block_chain_hash.sv */
// Chained 64-bit hash over a fixed-key 64-bit block cipher. Each item carries up to
// eight message bytes, byte 0 in bits 7:0; bytes at or above s_byte_count are zeroed,
// a count above 8 counts as 8 and a count of 0 leaves the chain untouched. An item
// with bytes passes a load state, then one cipher round per cycle in a single round
// unit (32 rounds), then a finish state; an empty item goes from load to finish.
// Items queue two deep ahead of the round unit, and a digest waits in an output
// register, so the input is taken while the engine works. On s_last the digest
// appears on m_digest and the chain restarts for the next message.
module gost_block_chain_hash
    import gbh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_data,
    input  logic [3:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest
);

    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    blk_item_t push_item;
    blk_item_t pop_item;

    gbh_front u_front (
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_block_data (s_block_data),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .push         (push),
        .push_item    (push_item),
        .full         (full)
    );

    gbh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    gbh_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop_item (pop_item),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_digest (m_digest)
    );

endmodule
